### sv/ttsb_pkg.sv
package ttsb_pkg;

	// cell layout: attribute in the upper bits, character in the lower bits
	localparam int CHAR_W = 7;
	localparam int ATTR_W = 8;
	localparam int CELL_W = CHAR_W + ATTR_W;

	// commands of the input channel
	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_SCROLL = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_READ   = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_DEFAULT = 2'd0;
	localparam logic [1:0] CFG_RED     = 2'd1;
	localparam logic [1:0] CFG_GREEN   = 2'd2;

	// byte codes
	localparam logic [7:0] ESC_BYTE        = 8'h1B;
	localparam logic [7:0] BS_BYTE         = 8'h08;
	localparam logic [7:0] LF_BYTE         = 8'h0A;
	localparam logic [7:0] CR_BYTE         = 8'h0D;
	localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
	localparam logic [7:0] MAX_PRINTABLE   = 8'd126;
	localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'h20;
	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

	// operations handed to the screen engine
	typedef enum logic [2:0] {
		OP_PUT,
		OP_ATTR,
		OP_SCROLL,
		OP_CLEAR,
		OP_READ
	} op_t;

	// attribute chosen by a recognized escape code
	typedef enum logic [1:0] {
		SEL_DEFAULT,
		SEL_RED,
		SEL_GREEN
	} attr_sel_t;

	typedef struct packed {
		logic               valid;
		op_t                op;
		logic [7:0]         data;
		attr_sel_t          sel;
		logic signed [10:0] delta;
		logic [4:0]         row;
		logic [6:0]         col;
	} scr_req_t;

endpackage

### sv/text_terminal_scrollback_unit.sv
// Channel   Handshake                 Payload
// in        in_valid / in_ready       cmd, data_byte, bypass_parser, string_end,
//                                     scroll_delta, read_row, read_col
// out       out_valid / out_ready     cell_char, cell_attr, cursor_column, scroll_position
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data (always ready)
//
// One item at a time. A byte write goes through the parser to the screen engine, and each
// further byte replayed or flushed is one more screen request; a cell read first reads the
// memory row, then selects the cell. Clear blanks the whole scrollback, one memory row per
// cycle; after reset the same pass runs with in_ready low. The next item can be taken once
// the result is registered; a finished result waits while the previous one is still unread.
module text_terminal_scrollback_unit #(
	parameter int SCROLLBACK_LINES = 512,
	parameter int LINE_WIDTH       = 80,
	parameter int VISIBLE_ROWS     = 23
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [7:0]         data_byte,
	input  logic               bypass_parser,
	input  logic               string_end,
	input  logic signed [10:0] scroll_delta,
	input  logic [4:0]         read_row,
	input  logic [6:0]         read_col,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [6:0]         cell_char,
	output logic [7:0]         cell_attr,
	output logic [6:0]         cursor_column,
	output logic [8:0]         scroll_position,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	typedef enum logic {
		T_IDLE,
		T_WAIT
	} tstate_t;

	tstate_t            state_q;
	logic [1:0]         cmd_q;
	logic [7:0]         default_q;
	logic [7:0]         red_q;
	logic [7:0]         green_q;
	logic               out_valid_q;
	logic [6:0]         cell_char_q;
	logic [7:0]         cell_attr_q;
	logic [6:0]         cursor_column_q;
	logic [8:0]         scroll_position_q;

	ttsb_pkg::scr_req_t top_req;
	ttsb_pkg::scr_req_t par_req;
	ttsb_pkg::scr_req_t scr_req;
	logic               scr_ready;
	logic               par_busy;
	logic               accept;
	logic               cfg_wr;
	logic               finish;
	logic [6:0]         scr_char;
	logic [7:0]         scr_attr;
	logic [6:0]         scr_column;
	logic [8:0]         scr_offset;

	assign cfg_ready       = 1'b1;
	assign cfg_wr          = cfg_valid && cfg_ready;
	assign in_ready        = (state_q == T_IDLE) && scr_ready && !par_busy;
	assign accept          = in_valid && in_ready;
	assign finish          = !par_busy && scr_ready;
	assign out_valid       = out_valid_q;
	assign cell_char       = cell_char_q;
	assign cell_attr       = cell_attr_q;
	assign cursor_column   = cursor_column_q;
	assign scroll_position = scroll_position_q;

	// steer commands other than byte writes straight to the screen engine
	always_comb begin
		top_req       = '0;
		top_req.valid = accept && (cmd != ttsb_pkg::CMD_WRITE);
		top_req.delta = scroll_delta;
		top_req.row   = read_row;
		top_req.col   = read_col;
		case (cmd)
			ttsb_pkg::CMD_SCROLL: top_req.op = ttsb_pkg::OP_SCROLL;
			ttsb_pkg::CMD_CLEAR:  top_req.op = ttsb_pkg::OP_CLEAR;
			default:              top_req.op = ttsb_pkg::OP_READ;
		endcase
		scr_req = par_busy ? par_req : top_req;
	end

	ttsb_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && (cmd == ttsb_pkg::CMD_WRITE)),
		.clear    (accept && (cmd == ttsb_pkg::CMD_CLEAR)),
		.data_byte(data_byte),
		.bypass   (bypass_parser),
		.flush    (string_end),
		.scr_ready(scr_ready),
		.req      (par_req),
		.busy     (par_busy)
	);

	ttsb_screen #(
		.SCROLLBACK_LINES(SCROLLBACK_LINES),
		.LINE_WIDTH      (LINE_WIDTH),
		.VISIBLE_ROWS    (VISIBLE_ROWS)
	) u_screen (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (scr_req),
		.ready        (scr_ready),
		.default_attr (default_q),
		.red_attr     (red_q),
		.green_attr   (green_q),
		.attr_load    (cfg_wr && (cfg_index == ttsb_pkg::CFG_DEFAULT)),
		.attr_load_val(cfg_data),
		.rd_char      (scr_char),
		.rd_attr      (scr_attr),
		.column       (scr_column),
		.offset       (scr_offset)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q <= ttsb_pkg::RESET_ATTR;
			red_q     <= 8'd4;
			green_q   <= 8'd2;
		end else if (cfg_wr) begin
			case (cfg_index)
				ttsb_pkg::CFG_DEFAULT: default_q <= cfg_data;
				ttsb_pkg::CFG_RED:     red_q     <= cfg_data;
				ttsb_pkg::CFG_GREEN:   green_q   <= cfg_data;
				default:               default_q <= default_q;
			endcase
		end
	end

	// item control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
			cmd_q       <= ttsb_pkg::CMD_WRITE;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (accept) begin
						cmd_q   <= cmd;
						state_q <= T_WAIT;
					end
				end
				default: begin
					if (finish && (!out_valid_q || out_ready)) begin
						out_valid_q       <= 1'b1;
						cursor_column_q   <= scr_column;
						scroll_position_q <= scr_offset;
						if (cmd_q == ttsb_pkg::CMD_READ) begin
							cell_char_q <= scr_char;
							cell_attr_q <= scr_attr;
						end else begin
							cell_char_q <= '0;
							cell_attr_q <= '0;
						end
						state_q <= T_IDLE;
					end else if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
			endcase
		end
	end

endmodule

### sv/ttsb_ram.sv
module ttsb_ram #(
	parameter int WIDTH = 1200,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/ttsb_parser.sv
module ttsb_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              clear,
	input  logic [7:0]        data_byte,
	input  logic              bypass,
	input  logic              flush,
	input  logic              scr_ready,
	output ttsb_pkg::scr_req_t req,
	output logic              busy
);

	localparam logic [7:0] LBRACKET = 8'h5B;
	localparam logic [7:0] DIGIT0   = 8'h30;
	localparam logic [7:0] DIGIT1   = 8'h31;
	localparam logic [7:0] DIGIT2   = 8'h32;
	localparam logic [7:0] DIGIT3   = 8'h33;
	localparam logic [7:0] LETTER_M = 8'h6D;

	typedef enum logic [2:0] {
		P_IDLE,
		P_DIRECT,
		P_PARSE,
		P_FLUSH_CHK,
		P_FLUSH
	} pstate_t;

	typedef enum logic [1:0] {
		CLS_PREFIX,
		CLS_MISMATCH,
		CLS_MATCH
	} cls_t;

	pstate_t          state_q;
	logic [3:0][7:0]  esc_q;
	logic [2:0]       esc_len_q;
	logic [4:0][7:0]  hold_q;
	logic [2:0]       cnt_q;
	logic             flush_q;
	cls_t             cls;
	logic             acc;

	// decide whether the held bytes still start a known code
	function automatic cls_t classify(input logic [4:0][7:0] b, input logic [2:0] n);
		cls_t k;
		if (b[0] != ttsb_pkg::ESC_BYTE) begin
			k = CLS_MISMATCH;
		end else if (n < 3'd2) begin
			k = CLS_PREFIX;
		end else if (b[1] != LBRACKET) begin
			k = CLS_MISMATCH;
		end else if (n < 3'd3) begin
			k = CLS_PREFIX;
		end else if (b[2] == DIGIT0) begin
			if (n < 3'd4) begin
				k = CLS_PREFIX;
			end else begin
				k = (b[3] == LETTER_M) ? CLS_MATCH : CLS_MISMATCH;
			end
		end else if (b[2] != DIGIT3) begin
			k = CLS_MISMATCH;
		end else if (n < 3'd4) begin
			k = CLS_PREFIX;
		end else if (b[3] != DIGIT1 && b[3] != DIGIT2) begin
			k = CLS_MISMATCH;
		end else if (n < 3'd5) begin
			k = CLS_PREFIX;
		end else begin
			k = (b[4] == LETTER_M) ? CLS_MATCH : CLS_MISMATCH;
		end
		return k;
	endfunction

	assign cls  = classify(hold_q, cnt_q);
	assign busy = (state_q != P_IDLE);
	assign acc  = req.valid && scr_ready;

	// build the request toward the screen engine
	always_comb begin
		req       = '0;
		req.op    = ttsb_pkg::OP_PUT;
		req.data  = hold_q[0];
		if (hold_q[2] == DIGIT0) begin
			req.sel = ttsb_pkg::SEL_DEFAULT;
		end else if (hold_q[3] == DIGIT1) begin
			req.sel = ttsb_pkg::SEL_RED;
		end else begin
			req.sel = ttsb_pkg::SEL_GREEN;
		end
		case (state_q)
			P_DIRECT: begin
				req.valid = 1'b1;
			end
			P_PARSE: begin
				if (cls == CLS_MATCH) begin
					req.valid = 1'b1;
					req.op    = ttsb_pkg::OP_ATTR;
				end else if (cls == CLS_MISMATCH) begin
					req.valid = 1'b1;
				end
			end
			P_FLUSH: begin
				req.valid = (cnt_q != 3'd0);
			end
			default: begin
				req.valid = 1'b0;
			end
		endcase
	end

	// parse sequencer: replay held bytes one at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= P_IDLE;
			esc_q     <= '0;
			esc_len_q <= '0;
			cnt_q     <= '0;
			flush_q   <= 1'b0;
			hold_q    <= '0;
		end else begin
			case (state_q)
				P_IDLE: begin
					if (clear) begin
						esc_q     <= '0;
						esc_len_q <= '0;
					end
					if (start) begin
						flush_q <= flush;
						if (bypass) begin
							hold_q[0] <= data_byte;
							state_q   <= P_DIRECT;
						end else begin
							for (int i = 0; i < 5; i++) begin
								if (i < int'(esc_len_q)) begin
									hold_q[i] <= esc_q[i[1:0]];
								end else if (i == int'(esc_len_q)) begin
									hold_q[i] <= data_byte;
								end else begin
									hold_q[i] <= 8'h00;
								end
							end
							cnt_q   <= esc_len_q + 3'd1;
							state_q <= P_PARSE;
						end
					end
				end
				P_DIRECT: begin
					if (acc) begin
						state_q <= P_FLUSH_CHK;
					end
				end
				P_PARSE: begin
					case (cls)
						CLS_PREFIX: begin
							esc_q     <= hold_q[3:0];
							esc_len_q <= cnt_q;
							state_q   <= P_FLUSH_CHK;
						end
						CLS_MATCH: begin
							if (acc) begin
								esc_q     <= '0;
								esc_len_q <= '0;
								state_q   <= P_FLUSH_CHK;
							end
						end
						default: begin
							if (acc) begin
								hold_q <= {8'h00, hold_q[4:1]};
								cnt_q  <= cnt_q - 3'd1;
								if (cnt_q == 3'd1) begin
									esc_q     <= '0;
									esc_len_q <= '0;
									state_q   <= P_FLUSH_CHK;
								end
							end
						end
					endcase
				end
				P_FLUSH_CHK: begin
					if (flush_q) begin
						hold_q    <= {8'h00, esc_q};
						cnt_q     <= esc_len_q;
						esc_q     <= '0;
						esc_len_q <= '0;
						state_q   <= P_FLUSH;
					end else begin
						state_q <= P_IDLE;
					end
				end
				P_FLUSH: begin
					if (cnt_q == 3'd0) begin
						state_q <= P_IDLE;
					end else if (acc) begin
						hold_q <= {8'h00, hold_q[4:1]};
						cnt_q  <= cnt_q - 3'd1;
					end
				end
				default: begin
					state_q <= P_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/ttsb_screen.sv
module ttsb_screen #(
	parameter int SCROLLBACK_LINES = 512,
	parameter int LINE_WIDTH       = 80,
	parameter int VISIBLE_ROWS     = 23
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ttsb_pkg::scr_req_t req,
	output logic              ready,
	input  logic [7:0]        default_attr,
	input  logic [7:0]        red_attr,
	input  logic [7:0]        green_attr,
	input  logic              attr_load,
	input  logic [7:0]        attr_load_val,
	output logic [6:0]        rd_char,
	output logic [7:0]        rd_attr,
	output logic [6:0]        column,
	output logic [8:0]        offset
);

	localparam int AW    = $clog2(SCROLLBACK_LINES);
	localparam int CW    = $clog2(LINE_WIDTH);
	localparam int ROW_W = LINE_WIDTH * ttsb_pkg::CELL_W;
	localparam int TW    = AW + 7;
	localparam int SW    = ((AW > 11) ? AW : 11) + 2;

	typedef logic [LINE_WIDTH-1:0][ttsb_pkg::CELL_W-1:0] row_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_PUT,
		S_WR,
		S_NL,
		S_SWEEP,
		S_RD_ADDR,
		S_RD_DATA
	} sstate_t;

	sstate_t                    state_q;
	logic [31:0]                lc_q;
	logic [AW-1:0]              slot_q;
	logic [CW-1:0]              col_q;
	logic [AW-1:0]              off_q;
	logic [7:0]                 cur_attr_q;
	logic [7:0]                 byte_q;
	logic [CW-1:0]              wcol_q;
	logic [ttsb_pkg::CELL_W-1:0] wcell_q;
	logic                       nl_q;
	logic [AW-1:0]              sweep_q;
	logic [7:0]                 sweep_attr_q;
	logic [AW-1:0]              top_q;
	logic [4:0]                 rrow_q;
	logic [6:0]                 rcol_q;
	logic                       rin_q;
	logic                       rvalid_q;
	logic [6:0]                 rd_char_q;
	logic [7:0]                 rd_attr_q;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	row_t                       wrow;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [ROW_W-1:0]           ram_rdata;
	row_t                       rrow;

	logic [AW-1:0]              max_off;
	logic [AW-1:0]              next_slot;
	logic [TW-1:0]              span;
	logic [AW-1:0]              top_new;
	logic [AW-1:0]              rd_dist;
	logic [AW:0]                rd_diff;
	logic [AW-1:0]              rslot;
	logic signed [SW-1:0]       scroll_sum;
	logic [AW-1:0]              scroll_new;
	logic                       is_print;
	logic                       is_bs;
	logic [CW:0]                col_inc;
	logic [ttsb_pkg::CELL_W-1:0] cell_sel;

	function automatic row_t blank_row(input logic [7:0] a);
		row_t r;
		for (int i = 0; i < LINE_WIDTH; i++) begin
			r[i] = {a, ttsb_pkg::SPACE_CHAR};
		end
		return r;
	endfunction

	ttsb_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SCROLLBACK_LINES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wrow),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rrow    = ram_rdata;
	assign ready   = (state_q == S_IDLE);
	assign rd_char = rd_char_q;
	assign rd_attr = rd_attr_q;
	assign column  = 7'(col_q);
	assign offset  = 9'(off_q);

	// kept history depth and the ring slot after the current line
	always_comb begin
		max_off   = (lc_q < 32'(SCROLLBACK_LINES - 1)) ? lc_q[AW-1:0]
			: AW'(SCROLLBACK_LINES - 1);
		if (lc_q == 32'hFFFF_FFFF || slot_q == AW'(SCROLLBACK_LINES - 1)) begin
			next_slot = '0;
		end else begin
			next_slot = slot_q + AW'(1);
		end
	end

	// view geometry: lines between the top visible row and the current line
	always_comb begin
		span    = TW'(VISIBLE_ROWS - 1) + TW'(off_q);
		top_new = (span < TW'(max_off)) ? span[AW-1:0] : max_off;
		rd_dist = top_q - AW'(rrow_q);
		rd_diff = {1'b0, slot_q} - {1'b0, rd_dist};
		rslot   = rd_diff[AW] ? AW'(rd_diff + (AW+1)'(SCROLLBACK_LINES)) : rd_diff[AW-1:0];
	end

	// clamp the scroll offset into the kept history
	always_comb begin
		scroll_sum = SW'($signed({1'b0, off_q})) + SW'($signed(req.delta));
		if (scroll_sum < 0) begin
			scroll_new = '0;
		end else if (scroll_sum > SW'($signed({1'b0, max_off}))) begin
			scroll_new = max_off;
		end else begin
			scroll_new = scroll_sum[AW-1:0];
		end
	end

	always_comb begin
		is_print = (byte_q >= ttsb_pkg::FIRST_PRINTABLE) && (byte_q <= ttsb_pkg::MAX_PRINTABLE);
		is_bs    = (byte_q == ttsb_pkg::BS_BYTE);
		col_inc  = {1'b0, col_q} + (CW+1)'(1);
		cell_sel = rrow[rcol_q[CW-1:0]];
	end

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		wrow      = rrow;
		ram_re    = 1'b0;
		ram_raddr = slot_q;
		case (state_q)
			S_INIT, S_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				wrow      = blank_row(sweep_attr_q);
			end
			S_PUT: begin
				if (is_print && col_q == '0) begin
					ram_we  = 1'b1;
					wrow    = blank_row(default_attr);
					wrow[0] = {cur_attr_q, byte_q[6:0]};
				end else if (is_print || (is_bs && col_q != '0)) begin
					ram_re = 1'b1;
				end
			end
			S_WR: begin
				ram_we         = 1'b1;
				wrow[wcol_q]   = wcell_q;
			end
			S_NL: begin
				ram_we    = 1'b1;
				ram_waddr = next_slot;
				wrow      = blank_row(default_attr);
			end
			S_RD_ADDR: begin
				ram_re    = 1'b1;
				ram_raddr = rslot;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// screen sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			lc_q         <= '0;
			slot_q       <= '0;
			col_q        <= '0;
			off_q        <= '0;
			cur_attr_q   <= ttsb_pkg::RESET_ATTR;
			sweep_q      <= '0;
			sweep_attr_q <= ttsb_pkg::RESET_ATTR;
			nl_q         <= 1'b0;
			rd_char_q    <= '0;
			rd_attr_q    <= '0;
		end else begin
			case (state_q)
				S_INIT, S_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == AW'(SCROLLBACK_LINES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						case (req.op)
							ttsb_pkg::OP_PUT: begin
								byte_q  <= req.data;
								state_q <= S_PUT;
							end
							ttsb_pkg::OP_ATTR: begin
								case (req.sel)
									ttsb_pkg::SEL_DEFAULT: cur_attr_q <= default_attr;
									ttsb_pkg::SEL_RED:     cur_attr_q <= red_attr;
									default:               cur_attr_q <= green_attr;
								endcase
							end
							ttsb_pkg::OP_SCROLL: begin
								off_q <= scroll_new;
							end
							ttsb_pkg::OP_CLEAR: begin
								lc_q         <= '0;
								slot_q       <= '0;
								col_q        <= '0;
								off_q        <= '0;
								cur_attr_q   <= default_attr;
								sweep_q      <= '0;
								sweep_attr_q <= default_attr;
								state_q      <= S_SWEEP;
							end
							default: begin
								top_q   <= top_new;
								rrow_q  <= req.row;
								rcol_q  <= req.col;
								rin_q   <= (32'(req.row) < 32'(VISIBLE_ROWS))
									&& (32'(req.col) < 32'(LINE_WIDTH));
								state_q <= S_RD_ADDR;
							end
						endcase
					end
				end
				S_PUT: begin
					state_q <= S_IDLE;
					if (byte_q == ttsb_pkg::LF_BYTE) begin
						state_q <= S_NL;
					end else if (byte_q == ttsb_pkg::CR_BYTE) begin
						col_q <= '0;
					end else if (is_bs) begin
						if (col_q != '0) begin
							col_q   <= col_q - CW'(1);
							wcol_q  <= col_q - CW'(1);
							wcell_q <= {cur_attr_q, ttsb_pkg::SPACE_CHAR};
							nl_q    <= 1'b0;
							state_q <= S_WR;
						end
					end else if (is_print) begin
						if (col_q == '0) begin
							col_q <= CW'(1);
						end else begin
							wcol_q  <= col_q;
							wcell_q <= {cur_attr_q, byte_q[6:0]};
							col_q   <= col_inc[CW-1:0];
							nl_q    <= (col_inc == (CW+1)'(LINE_WIDTH));
							state_q <= S_WR;
						end
					end
				end
				S_WR: begin
					state_q <= nl_q ? S_NL : S_IDLE;
				end
				S_NL: begin
					col_q   <= '0;
					lc_q    <= lc_q + 32'd1;
					slot_q  <= next_slot;
					off_q   <= '0;
					state_q <= S_IDLE;
				end
				S_RD_ADDR: begin
					rvalid_q <= rin_q && (AW'(rrow_q) <= top_q) && (TW'(rrow_q) <= TW'(top_q));
					state_q  <= S_RD_DATA;
				end
				S_RD_DATA: begin
					if (rvalid_q) begin
						rd_char_q <= cell_sel[ttsb_pkg::CHAR_W-1:0];
						rd_attr_q <= cell_sel[ttsb_pkg::CELL_W-1:ttsb_pkg::CHAR_W];
					end else begin
						rd_char_q <= ttsb_pkg::SPACE_CHAR;
						rd_attr_q <= default_attr;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (attr_load) begin
				cur_attr_q <= attr_load_val;
			end
		end
	end

endmodule

### sv/ttsb_checker.sv
module ttsb_checker #(
	parameter int SCROLLBACK_LINES = 512,
	parameter int LINE_WIDTH       = 80
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] cell_char,
	input logic [7:0] cell_attr,
	input logic [6:0] cursor_column,
	input logic [8:0] scroll_position
);

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cell_char)
			&& $stable(cell_attr) && $stable(cursor_column) && $stable(scroll_position))
		else $error("result changed while stalled");

	// one item in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in flight");

	// the cursor always lies inside the line
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(cursor_column) < 32'(LINE_WIDTH))
		else $error("cursor column beyond line width");

	// the scroll offset never leaves the ring
	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(scroll_position) < 32'(SCROLLBACK_LINES))
		else $error("scroll offset beyond scrollback");

endmodule

bind text_terminal_scrollback_unit ttsb_checker #(
	.SCROLLBACK_LINES(SCROLLBACK_LINES),
	.LINE_WIDTH      (LINE_WIDTH)
) u_ttsb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.cell_char      (cell_char),
	.cell_attr      (cell_attr),
	.cursor_column  (cursor_column),
	.scroll_position(scroll_position)
);

### verif/text_terminal_scrollback_unit_tb.sv
`default_nettype none

module text_terminal_scrollback_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINES = 512;
	localparam int WIDTH = 80;
	localparam int ROWS = 23;

	typedef struct {
		logic [1:0]         cmd;
		logic [7:0]         data_byte;
		logic               bypass_parser;
		logic               string_end;
		logic signed [10:0] scroll_delta;
		logic [4:0]         read_row;
		logic [6:0]         read_col;
	} term_item_t;

	typedef struct {
		logic [6:0] cell_char;
		logic [7:0] cell_attr;
		logic [6:0] cursor_column;
		logic [8:0] scroll_position;
	} term_view_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic [1:0] cmd, cfg_index;
	logic [7:0] data_byte, cfg_data;
	logic bypass_parser, string_end;
	logic signed [10:0] scroll_delta;
	logic [4:0] read_row;
	logic [6:0] read_col, cell_char, cursor_column;
	logic [7:0] cell_attr;
	logic [8:0] scroll_position;

	text_terminal_scrollback_unit DUT (.*);

	// shadow terminal state
	logic [ttsb_pkg::CELL_W-1:0] screen_cells [LINES*WIDTH];
	logic [31:0] line_num;
	int unsigned cur_col, view_off;
	logic [7:0] cur_attr, norm_attr, red_attr, green_attr;
	logic [7:0] esc_held [4];
	int unsigned esc_count;

	term_item_t pending_items[$];
	term_view_t expected_views[$];
	int errors, accepted, checked, reads_done, holdoff;
	bit idle_free, in_taken;

	function automatic logic [31:0] oldest_kept();
		longint total;
		total = longint'(line_num) + 1;
		return (total > LINES) ? 32'(total - LINES) : 32'd0;
	endfunction

	function automatic void blank_row(input logic [31:0] ln);
		int base;
		base = (ln % LINES) * WIDTH;
		for (int i = 0; i < WIDTH; i++) screen_cells[base+i] = {norm_attr, ttsb_pkg::SPACE_CHAR};
	endfunction

	function automatic void advance_line();
		cur_col = 0;
		line_num++;
		blank_row(line_num);
		view_off = 0;
	endfunction

	function automatic void emit_byte(input logic [7:0] c);
		int base;
		base = (line_num % LINES) * WIDTH;
		if (c == ttsb_pkg::LF_BYTE) advance_line();
		else if (c == ttsb_pkg::CR_BYTE) cur_col = 0;
		else if (c == ttsb_pkg::BS_BYTE) begin
			if (cur_col > 0) begin
				cur_col--;
				screen_cells[base+cur_col] = {cur_attr, ttsb_pkg::SPACE_CHAR};
			end
		end else if (c >= ttsb_pkg::FIRST_PRINTABLE && c <= ttsb_pkg::MAX_PRINTABLE) begin
			if (cur_col == 0) blank_row(line_num);
			screen_cells[base+cur_col] = {cur_attr, c[6:0]};
			cur_col++;
			if (cur_col >= WIDTH) advance_line();
		end
	endfunction

	// 0 prefix, 1 mismatch, 2 match
	function automatic int match_escape(input logic [7:0] b[5], input int n);
		if (b[0] != ttsb_pkg::ESC_BYTE) return 1;
		if (n < 2) return 0;
		if (b[1] != "[") return 1;
		if (n < 3) return 0;
		if (b[2] == "0") begin
			if (n < 4) return 0;
			return (b[3] == "m") ? 2 : 1;
		end
		if (b[2] != "3") return 1;
		if (n < 4) return 0;
		if (b[3] != "1" && b[3] != "2") return 1;
		if (n < 5) return 0;
		return (b[4] == "m") ? 2 : 1;
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		logic [7:0] b[5];
		int n, k;
		n = esc_count;
		for (int i = 0; i < n; i++) b[i] = esc_held[i];
		b[n] = c;
		n++;
		while (n > 0) begin
			k = match_escape(b, n);
			if (k == 0) break;
			if (k == 2) begin
				if (b[2] == "0") cur_attr = norm_attr;
				else if (b[3] == "1") cur_attr = red_attr;
				else cur_attr = green_attr;
				n = 0;
				break;
			end
			emit_byte(b[0]);
			for (int i = 0; i < 4; i++) b[i] = b[i+1];
			n--;
		end
		for (int i = 0; i < n; i++) esc_held[i] = b[i];
		esc_count = n;
	endfunction

	task automatic reset_terminal();
		for (int i = 0; i < LINES*WIDTH; i++)
			screen_cells[i] = {ttsb_pkg::RESET_ATTR, ttsb_pkg::SPACE_CHAR};
		line_num = 0; cur_col = 0; view_off = 0; esc_count = 0;
		cur_attr = ttsb_pkg::RESET_ATTR; norm_attr = 8'd7; red_attr = 8'd4; green_attr = 8'd2;
	endtask

	function automatic term_view_t predict_view(input term_item_t it);
		term_view_t v;
		longint mx, off, top, span, ln;
		logic [ttsb_pkg::CELL_W-1:0] c;
		v.cell_char = '0;
		v.cell_attr = '0;
		case (it.cmd)
			ttsb_pkg::CMD_WRITE: begin
				if (it.bypass_parser) emit_byte(it.data_byte);
				else parse_char(it.data_byte);
				if (it.string_end) begin
					for (int i = 0; i < esc_count; i++) emit_byte(esc_held[i]);
					esc_count = 0;
				end
			end
			ttsb_pkg::CMD_SCROLL: begin
				mx = longint'(line_num) - longint'(oldest_kept());
				off = longint'(view_off) + longint'(it.scroll_delta);
				if (off < 0) off = 0;
				if (off > mx) off = mx;
				view_off = off;
			end
			ttsb_pkg::CMD_CLEAR: begin
				line_num = 0; cur_col = 0; view_off = 0;
				cur_attr = norm_attr; esc_count = 0;
				for (int i = 0; i < LINES; i++) blank_row(i);
			end
			default: begin
				v.cell_char = ttsb_pkg::SPACE_CHAR;
				v.cell_attr = norm_attr;
				if (it.read_row < ROWS && it.read_col < WIDTH) begin
					span = ROWS - 1 + view_off;
					top = (longint'(line_num) >= span) ? longint'(line_num) - span : 0;
					if (top < oldest_kept()) top = oldest_kept();
					ln = top + it.read_row;
					if (ln <= line_num && ln >= oldest_kept()) begin
						c = screen_cells[(ln % LINES) * WIDTH + it.read_col];
						v.cell_char = c[6:0];
						v.cell_attr = c[14:7];
					end
				end
			end
		endcase
		if (view_off > line_num) view_off = line_num;
		v.cursor_column = cur_col[6:0];
		v.scroll_position = view_off[8:0];
		return v;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch on %s at result %0d: got %0d, expected %0d", what, checked, got, want);
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// record each accepted item and predict its result
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken) begin
			accepted++;
			expected_views.push_back(predict_view(pending_items.pop_front()));
		end
	end

	// drive items from the queue at the falling edge
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!in_valid || in_taken) begin
			if (pending_items.size() > 0 && (idle_free || $urandom_range(99) >= 32)) begin
				in_valid <= 1;
				cmd <= pending_items[0].cmd;
				data_byte <= pending_items[0].data_byte;
				bypass_parser <= pending_items[0].bypass_parser;
				string_end <= pending_items[0].string_end;
				scroll_delta <= pending_items[0].scroll_delta;
				read_row <= pending_items[0].read_row;
				read_col <= pending_items[0].read_col;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// receiver readiness, with a long hold-off on request
	always @(negedge clk) begin
		if (holdoff > 0) begin
			holdoff--;
			out_ready <= 0;
		end else begin
			out_ready <= idle_free || $urandom_range(99) >= 32;
		end
	end

	// check each result against the oldest expectation
	always @(posedge clk) begin
		term_view_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_views.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				want = expected_views.pop_front();
				if (cell_char !== want.cell_char)
					report_mismatch("cell_char", cell_char, want.cell_char);
				if (cell_attr !== want.cell_attr)
					report_mismatch("cell_attr", cell_attr, want.cell_attr);
				if (cursor_column !== want.cursor_column)
					report_mismatch("cursor_column", cursor_column, want.cursor_column);
				if (scroll_position !== want.scroll_position)
					report_mismatch("scroll_position", scroll_position, want.scroll_position);
				if (want.cell_char != 0) reads_done++;
			end
			checked++;
		end
	end

	function automatic term_item_t mk(input logic [1:0] c, input logic [7:0] b = 8'h41,
			input bit byp = 0, input bit se = 0, input int d = 0,
			input int r = 0, input int cl = 0);
		term_item_t it;
		it.cmd = c; it.data_byte = b; it.bypass_parser = byp; it.string_end = se;
		it.scroll_delta = 11'(d); it.read_row = 5'(r); it.read_col = 7'(cl);
		return it;
	endfunction

	function automatic term_item_t random_item();
		term_item_t it;
		int p;
		p = $urandom_range(99);
		it.data_byte = 8'($urandom); it.bypass_parser = ($urandom_range(9) == 0);
		it.string_end = ($urandom_range(14) == 0);
		it.scroll_delta = 11'($urandom); it.read_row = 5'($urandom);
		it.read_col = 7'($urandom);
		if (p < 55) begin
			it.cmd = ttsb_pkg::CMD_WRITE;
			p = $urandom_range(99);
			if (p < 60) it.data_byte = 8'($urandom_range(32, 126));
			else if (p < 70) it.data_byte = ttsb_pkg::LF_BYTE;
			else if (p < 75) it.data_byte = ttsb_pkg::CR_BYTE;
			else if (p < 80) it.data_byte = ttsb_pkg::BS_BYTE;
			else if (p < 90) it.data_byte = ttsb_pkg::ESC_BYTE;
		end else if (p < 65) begin
			it.cmd = ttsb_pkg::CMD_SCROLL;
			if ($urandom_range(1)) it.scroll_delta = $signed(11'($urandom_range(0, 40)) - 11'sd20);
		end else if (p < 66) begin
			it.cmd = ttsb_pkg::CMD_CLEAR;
		end else begin
			it.cmd = ttsb_pkg::CMD_READ;
			if ($urandom_range(9) != 0) begin
				it.read_row = 5'($urandom_range(22));
				it.read_col = 7'($urandom_range(79));
			end
		end
		return it;
	endfunction

	task automatic push_escape(input string s);
		for (int i = 0; i < s.len(); i++) pending_items.push_back(mk(ttsb_pkg::CMD_WRITE, s[i]));
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || in_valid || expected_views.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == ttsb_pkg::CFG_DEFAULT) begin
			norm_attr = val; cur_attr = val;
		end else if (idx == ttsb_pkg::CFG_RED) red_attr = val;
		else green_attr = val;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	initial begin
		logic [7:0] attr_sets[4][3];
		attr_sets = '{'{8'h00, 8'hFF, 8'h80}, '{8'hFF, 8'h00, 8'h01},
			'{8'h5A, 8'hA5, 8'h3C}, '{8'h07, 8'h04, 8'h02}};
		arst_n = 0; in_valid = 0; out_ready = 0; cfg_valid = 0;
		cfg_index = ttsb_pkg::CFG_DEFAULT; cfg_data = 0; cmd = ttsb_pkg::CMD_READ;
		data_byte = 0; bypass_parser = 0; string_end = 0;
		scroll_delta = 0; read_row = 0; read_col = 0; holdoff = 0; idle_free = 0;
		errors = 0; accepted = 0; checked = 0; reads_done = 0;
		reset_terminal();
		repeat (10) @(negedge clk);
		arst_n = 1;

		// directed: escapes, controls, bypass, flush, extremes
		push_escape("\x1b[31mR\x1b[32mG\x1b[0mN");
		push_escape("\x1b[3q");
		pending_items.push_back(mk(ttsb_pkg::CMD_WRITE, ttsb_pkg::ESC_BYTE, 0, 1));
		pending_items.push_back(mk(ttsb_pkg::CMD_WRITE, ttsb_pkg::ESC_BYTE));
		pending_items.push_back(mk(ttsb_pkg::CMD_WRITE, 8'hFF, 1, 1));
		pending_items.push_back(mk(ttsb_pkg::CMD_WRITE, ttsb_pkg::BS_BYTE));
		pending_items.push_back(mk(ttsb_pkg::CMD_WRITE, ttsb_pkg::CR_BYTE));
		pending_items.push_back(mk(ttsb_pkg::CMD_WRITE, 8'h7F));
		pending_items.push_back(mk(ttsb_pkg::CMD_WRITE, 8'h00));
		pending_items.push_back(mk(ttsb_pkg::CMD_WRITE, ttsb_pkg::LF_BYTE));
		pending_items.push_back(mk(ttsb_pkg::CMD_SCROLL, 0, 0, 0, 1023));
		pending_items.push_back(mk(ttsb_pkg::CMD_SCROLL, 0, 0, 0, -1024));
		pending_items.push_back(mk(ttsb_pkg::CMD_READ, 0, 0, 0, 0, 22, 0));
		pending_items.push_back(mk(ttsb_pkg::CMD_READ, 0, 0, 0, 0, 31, 127));
		pending_items.push_back(mk(ttsb_pkg::CMD_READ, 0, 0, 0, 0, 21, 79));
		pending_items.push_back(mk(ttsb_pkg::CMD_CLEAR));
		wait_idle();

		// random phases, one per attribute setting
		for (int ph = 0; ph < 4; ph++) begin
			for (int k = 0; k < 3; k++) write_reg(2'(k), attr_sets[ph][k]);
			idle_free = (ph == 2);
			for (int i = 0; i < 250; i++) begin
				if ($urandom_range(9) == 0)
					push_escape((i % 3 == 0) ? "\x1b[31m" : (i % 3 == 1) ? "\x1b[32m" : "\x1b[0m");
				else if (ph == 3 && i < 120)
					pending_items.push_back(mk(ttsb_pkg::CMD_WRITE,
						(i % 7 == 6) ? ttsb_pkg::LF_BYTE : 8'h61));
				else
					pending_items.push_back(random_item());
			end
			if (ph == 1) holdoff = 300;
			wait_idle();
		end
		idle_free = 0;

		$display("covered %0d items over 4 attribute settings plus directed escapes", accepted);
		$display("%0d results checked, %0d cell reads, %0d mismatches", checked, reads_done,
			errors);
		if (errors == 0 && expected_views.size() == 0)
			$display("text_terminal_scrollback_unit_tb: PASS");
		else
			$display("text_terminal_scrollback_unit_tb: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("text_terminal_scrollback_unit_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
